FILE: rtl/core/script_token_lexer_unit_defines.svh
// ----------------------------------------------------------------------------
// Script token lexer assertion macros
// Shared concurrent assertion forms used by the lexer RTL.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_TOKEN_LEXER_UNIT_DEFINES_SVH
`define SCRIPT_TOKEN_LEXER_UNIT_DEFINES_SVH

// Checked property that is switched off while reset is asserted.
`define STL_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("script token lexer assertion failed");

// Checked property that also holds across reset.
`define STL_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("script token lexer assertion failed");

`endif

FILE: rtl/core/stl_pkg.sv
// ----------------------------------------------------------------------------
// Script token lexer package
// Types, result codes and character constants shared by the lexer modules.
// ----------------------------------------------------------------------------
package stl_pkg;

   typedef enum logic [4:0] {
      MODE_IDLE    = 5'b00001,
      MODE_SLASH   = 5'b00010,
      MODE_COMMENT = 5'b00100,
      MODE_QUOTE   = 5'b01000,
      MODE_WORD    = 5'b10000
   } mode_type;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_END  = 2'd1,
      KIND_EOF  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] token_byte;
      logic       last;
   } res_type;

   localparam int unsigned MAX_RES   = 4;
   localparam int unsigned RES_IDX_W = $clog2(MAX_RES);
   localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);

   // All results caused by one input byte, in order; the final one has last set.
   typedef struct packed {
      res_type [MAX_RES-1:0] res;
   } desc_type;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHR_NUL    = 8'h00;
   localparam logic [7:0] CHR_NL     = 8'h0A;
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_QUOTE  = 8'h22;
   localparam logic [7:0] CHR_APOS   = 8'h27;
   localparam logic [7:0] CHR_LPAREN = 8'h28;
   localparam logic [7:0] CHR_RPAREN = 8'h29;
   localparam logic [7:0] CHR_SLASH  = 8'h2F;
   localparam logic [7:0] CHR_COLON  = 8'h3A;
   localparam logic [7:0] CHR_LBRACE = 8'h7B;
   localparam logic [7:0] CHR_RBRACE = 8'h7D;

endpackage

FILE: rtl/core/stl_front.sv
// ----------------------------------------------------------------------------
// Script token lexer front end
// Accepts text bytes, tracks the lexer mode and builds the result group.
// ----------------------------------------------------------------------------
module stl_front import stl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       q_full,
   output logic       q_push,
   output desc_type   q_push_data
);

   mode_type mode_ff;
   mode_type mode_in;
   logic     accept;
   logic     is_nul;
   logic     is_sep;
   logic     is_single;
   logic     is_slash;
   logic     is_quote;
   logic     is_nl;
   logic [RES_CNT_W-1:0] res_cnt;
   desc_type             desc;

   function automatic desc_type put(desc_type d, logic [RES_CNT_W-1:0] i,
                                    kind_type k, logic [7:0] b);
      desc_type r;
      r = d;
      r.res[i[RES_IDX_W-1:0]].kind       = k;
      r.res[i[RES_IDX_W-1:0]].token_byte = (k == KIND_BYTE) ? b : 8'h00;
      r.res[i[RES_IDX_W-1:0]].last       = 1'b0;
      return r;
   endfunction

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   assign is_nul    = (req_in_byte == CHR_NUL);
   assign is_sep    = (req_in_byte <= CHR_SPACE) || req_in_byte[7];
   assign is_slash  = (req_in_byte == CHR_SLASH);
   assign is_quote  = (req_in_byte == CHR_QUOTE);
   assign is_nl     = (req_in_byte == CHR_NL);
   assign is_single = (req_in_byte == CHR_LBRACE) || (req_in_byte == CHR_RBRACE) ||
                      (req_in_byte == CHR_LPAREN) || (req_in_byte == CHR_RPAREN) ||
                      (req_in_byte == CHR_APOS)   || (req_in_byte == CHR_COLON);

   always_comb begin
      logic [RES_CNT_W-1:0] n;
      logic [RES_CNT_W-1:0] lst;
      logic                 do_word;
      desc_type             d;
      n       = '0;
      d       = '0;
      do_word = 1'b0;
      mode_in = mode_ff;
      unique case (mode_ff)
         MODE_SLASH: begin
            if (is_slash) begin
               mode_in = MODE_COMMENT;
            end else begin
               // The held slash opens a word; this byte then continues or ends it.
               d       = put(d, n, KIND_BYTE, CHR_SLASH);
               n       = n + RES_CNT_W'(1);
               do_word = 1'b1;
            end
         end
         MODE_COMMENT: begin
            if (is_nul) begin
               d       = put(d, n, KIND_EOF, 8'h00);
               n       = n + RES_CNT_W'(1);
               mode_in = MODE_IDLE;
            end else if (is_nl) begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_QUOTE: begin
            if (is_quote) begin
               d       = put(d, n, KIND_END, 8'h00);
               n       = n + RES_CNT_W'(1);
               mode_in = MODE_IDLE;
            end else if (is_nul) begin
               d       = put(d, n, KIND_END, 8'h00);
               n       = n + RES_CNT_W'(1);
               d       = put(d, n, KIND_EOF, 8'h00);
               n       = n + RES_CNT_W'(1);
               mode_in = MODE_IDLE;
            end else begin
               d = put(d, n, KIND_BYTE, req_in_byte);
               n = n + RES_CNT_W'(1);
            end
         end
         MODE_WORD: begin
            do_word = 1'b1;
         end
         default: begin
            mode_in = MODE_IDLE;
            priority if (is_nul) begin
               d = put(d, n, KIND_EOF, 8'h00);
               n = n + RES_CNT_W'(1);
            end else if (is_sep) begin
               mode_in = MODE_IDLE;
            end else if (is_slash) begin
               mode_in = MODE_SLASH;
            end else if (is_quote) begin
               mode_in = MODE_QUOTE;
            end else if (is_single) begin
               d = put(d, n, KIND_BYTE, req_in_byte);
               n = n + RES_CNT_W'(1);
               d = put(d, n, KIND_END, 8'h00);
               n = n + RES_CNT_W'(1);
            end else begin
               d       = put(d, n, KIND_BYTE, req_in_byte);
               n       = n + RES_CNT_W'(1);
               mode_in = MODE_WORD;
            end
         end
      endcase

      if (do_word) begin
         priority if (is_single) begin
            d       = put(d, n, KIND_END, 8'h00);
            n       = n + RES_CNT_W'(1);
            d       = put(d, n, KIND_BYTE, req_in_byte);
            n       = n + RES_CNT_W'(1);
            d       = put(d, n, KIND_END, 8'h00);
            n       = n + RES_CNT_W'(1);
            mode_in = MODE_IDLE;
         end else if (is_nul) begin
            d       = put(d, n, KIND_END, 8'h00);
            n       = n + RES_CNT_W'(1);
            d       = put(d, n, KIND_EOF, 8'h00);
            n       = n + RES_CNT_W'(1);
            mode_in = MODE_IDLE;
         end else if (is_sep) begin
            d       = put(d, n, KIND_END, 8'h00);
            n       = n + RES_CNT_W'(1);
            mode_in = MODE_IDLE;
         end else begin
            d       = put(d, n, KIND_BYTE, req_in_byte);
            n       = n + RES_CNT_W'(1);
            mode_in = MODE_WORD;
         end
      end

      lst = n - RES_CNT_W'(1);
      if (n != '0) begin
         d.res[lst[RES_IDX_W-1:0]].last = 1'b1;
      end
      res_cnt = n;
      desc    = d;
   end

   assign q_push      = accept && (res_cnt != '0);
   assign q_push_data = desc;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

endmodule

FILE: rtl/core/stl_queue.sv
// ----------------------------------------------------------------------------
// Script token lexer result queue
// Short first-in first-out buffer of result groups between front and back.
// ----------------------------------------------------------------------------
module stl_queue import stl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_data,
   output logic     full,
   input  logic     pop,
   output desc_type head,
   output logic     empty
);

   desc_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wptr_ff;
   logic [QPTR_W-1:0]   wptr_in;
   logic [QPTR_W-1:0]   rptr_ff;
   logic [QPTR_W-1:0]   rptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rptr_in = (rptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/stl_back.sv
// ----------------------------------------------------------------------------
// Script token lexer back end
// Unrolls queued result groups into single results on the output register.
// ----------------------------------------------------------------------------
module stl_back import stl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  desc_type   q_head,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_token_byte,
   output logic       rsp_last
);

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   res_type              out_ff;
   res_type              out_in;
   logic                 busy_ff;
   logic                 busy_in;
   desc_type             cur_ff;
   desc_type             cur_in;
   logic [RES_IDX_W-1:0] idx_ff;
   logic [RES_IDX_W-1:0] idx_in;
   logic                 load;
   res_type              pick;

   // The output register takes a new result whenever it is empty or being drained.
   assign load = !rsp_valid_ff || !rsp_stall;
   assign pick = cur_ff.res[idx_ff];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      busy_in      = busy_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      q_pop        = 1'b0;
      if (load) begin
         if (busy_ff) begin
            rsp_valid_in = 1'b1;
            out_in       = pick;
            idx_in       = idx_ff + RES_IDX_W'(1);
            busy_in      = !pick.last;
         end else if (!q_empty) begin
            q_pop        = 1'b1;
            rsp_valid_in = 1'b1;
            out_in       = q_head.res[0];
            cur_in       = q_head;
            idx_in       = RES_IDX_W'(1);
            busy_in      = !q_head.res[0].last;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         busy_ff      <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      cur_ff <= cur_in;
      idx_ff <= idx_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = out_ff.kind;
   assign rsp_token_byte = out_ff.token_byte;
   assign rsp_last       = out_ff.last;

endmodule

FILE: rtl/core/script_token_lexer_unit.sv
// ----------------------------------------------------------------------------
// Script token lexer unit
// Streams script text in, one byte per req_ transfer, and streams tokens out
// on the rsp_ channel: token bytes, end-of-token and end-of-input markers,
// with rsp_last set on the final result caused by each input byte.
// A byte may cause no result (whitespace, comments, a held slash) or up to
// four. The front end takes one byte per cycle into a four-group queue while
// the queue is not full; the back end drives one result per cycle from its
// output register while rsp_stall is low. When the queue is empty, the first
// result of a byte goes into the queue and then into the output register.
// Input runs at one byte per cycle as long as bytes average no more than one
// result; the single output register sets that limit, and req_stall rises
// only while the queue is full. A stalled rsp_ result holds its value while
// new bytes keep filling the queue. Synchronous reset empties the queue,
// drops any pending result and returns the lexer to the idle state.
`include "script_token_lexer_unit_defines.svh"

module script_token_lexer_unit import stl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_token_byte,
   output logic       rsp_last
);

   logic     q_push;
   logic     q_pop;
   logic     q_full;
   logic     q_empty;
   desc_type q_push_data;
   desc_type q_head;

   stl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   stl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   stl_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_token_byte (rsp_token_byte),
      .rsp_last       (rsp_last)
   );

   `STL_ASSERT(a_marker_byte_zero, clock, reset, rsp_valid && (rsp_kind != KIND_BYTE) |-> rsp_token_byte == 8'h00)
   `STL_ASSERT(a_eof_is_last, clock, reset, rsp_valid && (rsp_kind == KIND_EOF) |-> rsp_last)
   `STL_ASSERT(a_no_push_when_full, clock, reset, q_full |-> !q_push)
   `STL_ASSERT_ALWAYS(a_reset_clears_output, clock, reset |=> !rsp_valid)

endmodule

FILE: tb/tb_script_token_lexer_unit.sv
// ----------------------------------------------------------------------------
// Script token lexer unit testbench
// Feeds script text through the req_ channel, with random gaps and random
// rsp_ stalls. A scoreboard tracks the lexer state, predicts every token
// byte and marker, and compares each rsp_ transfer against the oldest
// expected result.
// ----------------------------------------------------------------------------
module tb_script_token_lexer_unit import stl_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_BYTES = 70;
   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned DRAIN_CYCLES = 20;

   // Scoreboard: tracks the lexer mode and the results still owed on rsp_.
   class lexer_scoreboard;
      mode_type    mode;
      res_type     expected_q[$];
      res_type     batch[$];
      int unsigned errors;
      int unsigned bytes_in;
      int unsigned results_out;
      int unsigned tokens_out;
      int unsigned eofs_out;

      function new();
         mode        = MODE_IDLE;
         errors      = 0;
         bytes_in    = 0;
         results_out = 0;
         tokens_out  = 0;
         eofs_out    = 0;
      endfunction

      static function bit is_single(logic [7:0] b);
         return b == CHR_LBRACE || b == CHR_RBRACE || b == CHR_LPAREN ||
                b == CHR_RPAREN || b == CHR_APOS || b == CHR_COLON;
      endfunction

      // High bytes separate tokens since the original text used signed chars.
      static function bit is_separator(logic [7:0] b);
         return (b <= CHR_SPACE) || b[7];
      endfunction

      function void add(kind_type k, logic [7:0] b);
         res_type r;
         r.kind       = k;
         r.token_byte = (k == KIND_BYTE) ? b : 8'h00;
         r.last       = 1'b0;
         batch.push_back(r);
      endfunction

      // A byte that follows at least one byte of a word.
      function void after_word(logic [7:0] b);
         if (is_single(b)) begin
            add(KIND_END, 8'h00);
            add(KIND_BYTE, b);
            add(KIND_END, 8'h00);
            mode = MODE_IDLE;
         end else if (b == CHR_NUL) begin
            add(KIND_END, 8'h00);
            add(KIND_EOF, 8'h00);
            mode = MODE_IDLE;
         end else if (is_separator(b)) begin
            add(KIND_END, 8'h00);
            mode = MODE_IDLE;
         end else begin
            add(KIND_BYTE, b);
            mode = MODE_WORD;
         end
      endfunction

      function void note_input(logic [7:0] b);
         res_type r;
         bytes_in++;
         batch.delete();
         case (mode)
            MODE_SLASH: begin
               if (b == CHR_SLASH) begin
                  mode = MODE_COMMENT;
               end else begin
                  add(KIND_BYTE, CHR_SLASH);
                  after_word(b);
               end
            end
            MODE_COMMENT: begin
               if (b == CHR_NUL) begin
                  add(KIND_EOF, 8'h00);
                  mode = MODE_IDLE;
               end else if (b == CHR_NL) begin
                  mode = MODE_IDLE;
               end
            end
            MODE_QUOTE: begin
               if (b == CHR_QUOTE) begin
                  add(KIND_END, 8'h00);
                  mode = MODE_IDLE;
               end else if (b == CHR_NUL) begin
                  add(KIND_END, 8'h00);
                  add(KIND_EOF, 8'h00);
                  mode = MODE_IDLE;
               end else begin
                  add(KIND_BYTE, b);
               end
            end
            MODE_WORD: after_word(b);
            default: begin
               mode = MODE_IDLE;
               if (b == CHR_NUL) begin
                  add(KIND_EOF, 8'h00);
               end else if (is_separator(b)) begin
                  mode = MODE_IDLE;
               end else if (b == CHR_SLASH) begin
                  mode = MODE_SLASH;
               end else if (b == CHR_QUOTE) begin
                  mode = MODE_QUOTE;
               end else if (is_single(b)) begin
                  add(KIND_BYTE, b);
                  add(KIND_END, 8'h00);
               end else begin
                  add(KIND_BYTE, b);
                  mode = MODE_WORD;
               end
            end
         endcase
         if (batch.size() > 0) begin
            r = batch.pop_back();
            r.last = 1'b1;
            batch.push_back(r);
         end
         foreach (batch[i]) expected_q.push_back(batch[i]);
      endfunction

      function void check_result(logic [1:0] kind, logic [7:0] tok, logic last);
         res_type want;
         results_out++;
         if (kind == KIND_END) tokens_out++;
         if (kind == KIND_EOF) eofs_out++;
         if (expected_q.size() == 0) begin
            errors++;
            $error("unexpected rsp transfer: kind %0d, token_byte 0x%02h, last %0d",
                   kind, tok, last);
            return;
         end
         want = expected_q.pop_front();
         if (kind !== want.kind) begin
            errors++;
            $error("rsp_kind mismatch: expected %0d, actual %0d", want.kind, kind);
         end
         if (tok !== want.token_byte) begin
            errors++;
            $error("rsp_token_byte mismatch: expected 0x%02h, actual 0x%02h",
                   want.token_byte, tok);
         end
         if (last !== want.last) begin
            errors++;
            $error("rsp_last mismatch: expected %0d, actual %0d", want.last, last);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte    = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_token_byte;
   logic       rsp_last;

   lexer_scoreboard sb;
   logic [7:0]      text_q[$];
   bit              calm        = 1'b0;
   int unsigned     idle_cycles = 0;
   int unsigned     stall_left  = 0;
   int unsigned     stall_len;
   bit              moved;

   // Word with a brace, a comment, quoted high byte, empty string, slash
   // before a single, slash and quote inside a word, comment ended by NUL,
   // unterminated quote, NUL while idle, slash before a word, single-byte
   // tokens, slash before NUL.
   logic [7:0] directed_text[$] = '{
      8'h61, CHR_LBRACE,
      CHR_SLASH, CHR_SLASH, CHR_NL,
      CHR_QUOTE, 8'hFF, CHR_QUOTE,
      CHR_QUOTE, CHR_QUOTE,
      CHR_SLASH, CHR_LPAREN,
      8'h61, CHR_SLASH, CHR_QUOTE, 8'h80,
      CHR_SLASH, CHR_SLASH, CHR_NUL,
      CHR_QUOTE, 8'h01, CHR_NUL,
      CHR_NUL,
      CHR_SLASH, 8'h7F, CHR_COLON,
      CHR_APOS, CHR_RPAREN, CHR_RBRACE,
      CHR_SLASH, CHR_NUL
   };

   script_token_lexer_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_token_byte (rsp_token_byte),
      .rsp_last       (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Mostly no gap, some short ones and a few long ones.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] word_char(bit first);
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(33, 127));
      end while (lexer_scoreboard::is_single(b) ||
                 (first && (b == CHR_SLASH || b == CHR_QUOTE)));
      return b;
   endfunction

   function automatic logic [7:0] text_char(logic [7:0] avoid_a, logic [7:0] avoid_b);
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b == avoid_a || b == avoid_b);
      return b;
   endfunction

   // Appends one well-formed piece of script text, or a little noise.
   task automatic add_fragment();
      int unsigned pick;
      int unsigned n;
      logic [7:0]  singles[6];
      singles = '{CHR_LBRACE, CHR_RBRACE, CHR_LPAREN, CHR_RPAREN, CHR_APOS, CHR_COLON};
      pick = $urandom_range(0, 99);
      n    = $urandom_range(0, 5);
      if (pick < 30) begin
         for (int i = 0; i <= n; i++) text_q.push_back(word_char(i == 0));
      end else if (pick < 45) begin
         for (int i = 0; i < 1 + n / 2; i++) begin
            case ($urandom_range(0, 3))
               0:       text_q.push_back(CHR_SPACE);
               1:       text_q.push_back(CHR_NL);
               2:       text_q.push_back(8'($urandom_range(1, 32)));
               default: text_q.push_back(8'($urandom_range(128, 255)));
            endcase
         end
      end else if (pick < 57) begin
         text_q.push_back(CHR_QUOTE);
         for (int i = 0; i < n; i++) text_q.push_back(text_char(CHR_QUOTE, CHR_NUL));
         text_q.push_back(($urandom_range(0, 9) == 0) ? CHR_NUL : CHR_QUOTE);
      end else if (pick < 65) begin
         text_q.push_back(CHR_SLASH);
         text_q.push_back(CHR_SLASH);
         for (int i = 0; i < n; i++) text_q.push_back(text_char(CHR_NL, CHR_NUL));
         text_q.push_back(($urandom_range(0, 7) == 0) ? CHR_NUL : CHR_NL);
      end else if (pick < 77) begin
         text_q.push_back(singles[$urandom_range(0, 5)]);
      end else if (pick < 85) begin
         text_q.push_back(CHR_SLASH);
         text_q.push_back(text_char(CHR_SLASH, CHR_SLASH));
      end else if (pick < 89) begin
         text_q.push_back(CHR_NUL);
      end else begin
         for (int i = 0; i < 1 + n / 2; i++) text_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // Called at a rising edge; returns at the edge where the byte is taken.
   task automatic send_byte(logic [7:0] b);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left = stall_left - 1;
      end else begin
         stall_len = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
         rsp_stall  <= (stall_len > 0);
         stall_left = (stall_len > 0) ? stall_len - 1 : 0;
      end
   end

   // Transfer monitor and watchdog.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         moved = 1'b0;
         if (req_valid && !req_stall) begin
            sb.note_input(req_in_byte);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_kind, rsp_token_byte, rsp_last);
            moved = 1'b1;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      int unsigned random_sent;
      int unsigned chunk;
      sb = new();
      random_sent = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_text[i]) send_byte(directed_text[i]);

      // Phases of about twenty bytes; roughly one in four runs with no idling.
      while (random_sent < RANDOM_BYTES) begin
         calm  = ($urandom_range(0, 3) == 0);
         chunk = 0;
         while (chunk < 20) begin
            add_fragment();
            while (text_q.size() > 0) begin
               send_byte(text_q.pop_front());
               chunk++;
            end
         end
         random_sent += chunk;
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.errors++;
         $error("%0d expected results never arrived", sb.pending());
      end

      $display("Lexed %0d input bytes into %0d results:", sb.bytes_in, sb.results_out);
      $display("%0d token ends and %0d end-of-input markers.",
               sb.tokens_out, sb.eofs_out);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
